@@ hw/rtl/tdc_pkg.sv @@
// Shared widths, codes, queue entry and divider handshake types for the tick deadline unit.
`default_nettype none

package tdc_pkg;

  // Field widths.
  localparam int TIME_W = 64;
  localparam int TICK_W = 32;
  localparam int CORE_W = 2;

  // Default core count and depth of the queue between front and back.
  localparam int NUM_CORES_DEF = 4;
  localparam int QUEUE_DEPTH   = 2;

  // Command codes carried on the request channel.
  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Register reset value and tick saturation limit.
  localparam logic [TICK_W-1:0] CPT_RESET = TICK_W'(1000);
  localparam logic [TICK_W-1:0] TICKS_MAX = '1;

  // Operation class decided by the front.
  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_READ  = 2'd1,
    OP_NULL  = 2'd2
  } tdc_op_t;

  // One classified word waiting in the queue.
  typedef struct packed {
    tdc_op_t             op;
    logic [CORE_W-1:0]   core_index;
    logic [TIME_W-1:0]   now;
  } tdc_entry_t;

  // Request to the iterative divider.
  typedef struct packed {
    logic                start;
    logic [TIME_W-1:0]   dividend;
    logic [TICK_W-1:0]   divisor;
  } tdc_div_req_t;

  // Status and result from the iterative divider.
  typedef struct packed {
    logic                busy;
    logic                done;
    logic [TIME_W-1:0]   quotient;
  } tdc_div_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/tdc_ifs.sv @@
// Request and response channel interfaces of the tick deadline unit.
`default_nettype none

interface tdc_req_if import tdc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [CORE_W-1:0]   core_index;
  logic [TIME_W-1:0]   now;

  modport source (output valid, output cmd, output core_index, output now, input ready);
  modport sink   (input valid, input cmd, input core_index, input now, output ready);
endinterface

interface tdc_rsp_if import tdc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TICK_W-1:0]   ticks;
  logic [TIME_W-1:0]   next_deadline;
  logic [TIME_W-1:0]   elapsed_cycles;

  modport source (output valid, output ticks, output next_deadline, output elapsed_cycles,
                  input ready);
  modport sink   (input valid, input ticks, input next_deadline, input elapsed_cycles,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tick_deadline_catchup_unit.sv @@
// Order of work: a read or an unknown-core word passes the check and write-back states;
// an event that restarts its deadline also passes the multiply and add states, and a catch-up
// event first waits on the 64-step divider that counts the elapsed periods.
// The back end works on one word at a time;
// a two-entry queue keeps accepting words meanwhile.
// Reset (rst, synchronous) clears all deadlines to zero and sets the period to 1000.
`default_nettype none

module tick_deadline_catchup_unit import tdc_pkg::*; #(
  parameter int NUM_CORES = NUM_CORES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata,
  tdc_req_if.sink           req,
  tdc_rsp_if.source         rsp
);

  logic         q_push;
  logic         q_pop;
  logic         q_full;
  logic         q_empty;
  tdc_entry_t   push_entry;
  tdc_entry_t   pop_entry;
  tdc_div_req_t div_req;
  tdc_div_rsp_t div_rsp;

  // Classify incoming words.
  tdc_front #(
    .NUM_CORES (NUM_CORES)
  ) u_front (
    .req     (req),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  // Buffer between front and back.
  tdc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  // Period counting unit.
  tdc_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Deadline state and result generation.
  tdc_back #(
    .NUM_CORES (NUM_CORES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .q_entry   (pop_entry),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

@@ hw/rtl/tdc_front.sv @@
// Front end: accepts request words and classifies them before they enter the queue.
`default_nettype none

module tdc_front import tdc_pkg::*; #(
  parameter int NUM_CORES = NUM_CORES_DEF
) (
  tdc_req_if.sink    req,
  input  logic       q_full,
  output logic       q_push,
  output tdc_entry_t q_entry
);

  logic in_range;

  // A core index past the last core becomes a null operation.
  assign in_range = 32'(req.core_index) < 32'(NUM_CORES);

  // Classify the word.
  always_comb begin
    q_entry.core_index = req.core_index;
    q_entry.now        = req.now;
    if (!in_range) begin
      q_entry.op = OP_NULL;
    end else if (req.cmd == CMD_READ) begin
      q_entry.op = OP_READ;
    end else begin
      q_entry.op = OP_EVENT;
    end
  end

  // Take a word whenever the queue has room.
  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full;

endmodule

`default_nettype wire

@@ hw/rtl/tdc_queue.sv @@
// Short FIFO that decouples the front end from the back end.
`default_nettype none

module tdc_queue import tdc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  tdc_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output tdc_entry_t pop_entry,
  output logic       empty
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  tdc_entry_t       slots [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full      = count == CntW'(QUEUE_DEPTH);
  assign empty     = count == '0;
  assign pop_entry = slots[rd_ptr];

  // Pointer and fill count updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tdc_divider.sv @@
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
`default_nettype none

module tdc_divider import tdc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  tdc_div_req_t req,
  output tdc_div_rsp_t rsp
);

  localparam int CntW = $clog2(TIME_W + 1);

  logic [TICK_W-1:0] rem;
  logic [TICK_W-1:0] dsr;
  logic [TIME_W-1:0] quo;
  logic [CntW-1:0]   cnt;
  logic              busy;
  logic              done;
  logic [TICK_W:0]   trial;
  logic [TICK_W:0]   diff;
  logic              fits;

  // One trial subtraction per step; the remainder always stays below the divisor.
  assign trial = {rem, quo[TIME_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = !diff[TICK_W];

  // Step counter and status.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CntW'(TIME_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: the dividend shifts out as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
      quo <= {quo[TIME_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

@@ hw/rtl/tdc_back.sv @@
// Back end: holds the per-core deadlines, runs the catch-up sequence and registers the result.
`default_nettype none

module tdc_back import tdc_pkg::*; #(
  parameter int NUM_CORES = NUM_CORES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata,
  input  logic              q_empty,
  input  tdc_entry_t        q_entry,
  output logic              q_pop,
  output tdc_div_req_t      div_req,
  input  tdc_div_rsp_t      div_rsp,
  tdc_rsp_if.source         rsp
);

  localparam int CoreIdxW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int IdxExtW  = (CoreIdxW > CORE_W) ? CoreIdxW : CORE_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_DIV   = 6'b000100,
    S_MUL   = 6'b001000,
    S_ADD   = 6'b010000,
    S_WB    = 6'b100000
  } state_t;

  state_t              state;
  state_t              state_next;

  logic [TICK_W-1:0]   cycles_per_tick;
  logic [TICK_W-1:0]   period;
  logic [TIME_W-1:0]   cur_deadline  [NUM_CORES];
  logic [TIME_W-1:0]   prev_deadline [NUM_CORES];

  tdc_op_t             op_r;
  logic [CoreIdxW-1:0] idx_r;
  logic [TIME_W-1:0]   now_r;
  logic [TIME_W-1:0]   base_r;
  logic [TICK_W-1:0]   ticks_r;
  logic [TIME_W-1:0]   prod_r;
  logic [TICK_W-1:0]   res_ticks;
  logic [TIME_W-1:0]   res_nd;
  logic [TIME_W-1:0]   res_el;

  logic                out_valid;
  logic [TICK_W-1:0]   out_ticks;
  logic [TIME_W-1:0]   out_nd;
  logic [TIME_W-1:0]   out_el;

  logic [IdxExtW-1:0]  idx_ext;
  logic [TIME_W-1:0]   cur_sel;
  logic [TIME_W-1:0]   prev_sel;
  logic                restart;
  logic [TICK_W-1:0]   ticks_sat;
  logic [TIME_W-1:0]   sum_nd;
  logic                out_load;

  // A period of zero counts as one cycle.
  assign period = (cycles_per_tick == '0) ? TICK_W'(1) : cycles_per_tick;

  // Array index taken from the queued core index.
  assign idx_ext = IdxExtW'(q_entry.core_index);

  // Deadline lookups for the current word.
  assign cur_sel  = cur_deadline[idx_r];
  assign prev_sel = prev_deadline[idx_r];
  assign restart  = (cur_sel == '0) || (now_r < cur_sel);

  // Whole periods passed plus one, saturating.
  assign ticks_sat = (div_rsp.quotient >= TIME_W'(TICKS_MAX)) ? TICKS_MAX
                   : div_rsp.quotient[TICK_W-1:0] + 1'b1;

  assign sum_nd = base_r + prod_r;

  // Divider launch on a catch-up event.
  assign div_req.start    = (state == S_CHECK) && (op_r == OP_EVENT) && !restart;
  assign div_req.dividend = now_r - cur_sel;
  assign div_req.divisor  = period;

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign out_load = (state == S_WB) && (!out_valid || rsp.ready);

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (op_r == OP_EVENT) begin
          state_next = restart ? S_MUL : S_DIV;
        end else begin
          state_next = S_WB;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: state_next = S_ADD;
      S_ADD: state_next = S_WB;
      S_WB: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Period register and per-core deadlines.
  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_per_tick <= CPT_RESET;
      for (int k = 0; k < NUM_CORES; k++) begin
        cur_deadline[k]  <= '0;
        prev_deadline[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cycles_per_tick <= cfg_wdata;
      end
      if (state == S_ADD) begin
        cur_deadline[idx_r]  <= sum_nd;
        prev_deadline[idx_r] <= base_r;
      end
    end
  end

  // Working registers of the word in progress.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r  <= q_entry.op;
      idx_r <= idx_ext[CoreIdxW-1:0];
      now_r <= q_entry.now;
    end
    if (state == S_CHECK) begin
      unique case (op_r)
        OP_EVENT: begin
          base_r  <= restart ? now_r : cur_sel;
          ticks_r <= TICK_W'(1);
        end
        OP_READ: begin
          res_ticks <= '0;
          res_nd    <= cur_sel;
          res_el    <= now_r - prev_sel;
        end
        default: begin
          res_ticks <= '0;
          res_nd    <= '0;
          res_el    <= '0;
        end
      endcase
    end
    if ((state == S_DIV) && div_rsp.done) begin
      ticks_r <= ticks_sat;
    end
    if (state == S_MUL) begin
      prod_r <= TIME_W'(ticks_r) * TIME_W'(period);
    end
    if (state == S_ADD) begin
      res_ticks <= ticks_r;
      res_nd    <= sum_nd;
      res_el    <= now_r - base_r;
    end
    if (out_load) begin
      out_ticks <= res_ticks;
      out_nd    <= res_nd;
      out_el    <= res_el;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.ticks          = out_ticks;
  assign rsp.next_deadline  = out_nd;
  assign rsp.elapsed_cycles = out_el;

  // A word for a missing core reports all zeros.
  a_null_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB) && (op_r == OP_NULL) |->
      (res_ticks == '0) && (res_nd == '0) && (res_el == '0))
    else $error("null word produced a nonzero result");

  // An event always counts at least one tick.
  a_event_ticks: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB) && (op_r == OP_EVENT) |-> (res_ticks != '0))
    else $error("event result has zero ticks");

  // The deadline update lands in the entry of the word in progress.
  a_deadline_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD) |=> (cur_deadline[$past(idx_r)] == $past(sum_nd)))
    else $error("current deadline not updated");

  // While waiting on the divider, it is either working or finishing.
  a_div_active: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_rsp.busy || div_rsp.done))
    else $error("waiting on an idle divider");

endmodule

`default_nettype wire

@@ test/tb_tick_deadline_catchup_unit.sv @@
// Self-checking testbench for the tick deadline catch-up unit with directed and random words.
`timescale 1ns / 1ps

module tb_tick_deadline_catchup_unit;
  import tdc_pkg::*;

  localparam int CORES         = NUM_CORES_DEF;
  localparam int RUN_LIMIT     = 1000000;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_PRINTED   = 40;

  // One expected response word.
  typedef struct {
    logic [TICK_W-1:0] ticks;
    logic [TIME_W-1:0] next_deadline;
    logic [TIME_W-1:0] elapsed_cycles;
  } tick_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [TICK_W-1:0] cfg_wdata;

  tdc_req_if req_ch ();
  tdc_rsp_if rsp_ch ();

  tick_deadline_catchup_unit #(.NUM_CORES(CORES)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Shadow copy of the period register and of the per-core deadlines.
  logic [TICK_W-1:0] tick_period;
  logic [TIME_W-1:0] core_deadline      [CORES];
  logic [TIME_W-1:0] core_prev_deadline [CORES];

  tick_result_t pending_results [$];

  int error_count     = 0;
  int event_count     = 0;
  int read_count      = 0;
  int checked_count   = 0;
  int period_writes   = 0;
  int saturated_count = 0;
  int send_gap_pct    = 0;
  int recv_stall_pct  = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles with %0d results outstanding", RUN_LIMIT,
             pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // The effective period: a zero register value counts as one cycle.
  function automatic logic [TIME_W-1:0] tick_length();
    return (tick_period == '0) ? 64'd1 : {32'd0, tick_period};
  endfunction

  // Predict the response to one word and update the shadow deadlines.
  function automatic tick_result_t apply_command(logic cmd, logic [CORE_W-1:0] core,
                                                 logic [TIME_W-1:0] now);
    tick_result_t      res;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] whole;
    logic [TIME_W-1:0] count;
    period = tick_length();
    count  = '0;
    if (int'(core) >= CORES) begin
      res.ticks          = '0;
      res.next_deadline  = '0;
      res.elapsed_cycles = '0;
      return res;
    end
    if (cmd == CMD_EVENT) begin
      base = core_deadline[core];
      if (base == '0 || now < base) begin
        // Not started yet or deadline still ahead: restart from now.
        base  = now;
        count = 64'd1;
      end else begin
        whole = (now - base) / period;
        if (whole >= {32'd0, TICKS_MAX}) begin
          count = {32'd0, TICKS_MAX};
          saturated_count++;
        end else begin
          count = whole + 64'd1;
        end
      end
      core_prev_deadline[core] = base;
      core_deadline[core]      = base + count * period;
      event_count++;
    end else begin
      read_count++;
    end
    res.ticks          = count[TICK_W-1:0];
    res.next_deadline  = core_deadline[core];
    res.elapsed_cycles = now - core_prev_deadline[core];
    return res;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(string what, logic [TIME_W-1:0] got,
                                 logic [TIME_W-1:0] want);
    if (error_count < MAX_PRINTED) begin
      $display("[%0t] mismatch on %s: got 0x%h, expected 0x%h", $time, what, got, want);
    end
    error_count++;
  endtask

  // Send one request word, with random gaps before it, and record its prediction.
  task automatic send_word(logic cmd, logic [CORE_W-1:0] core, logic [TIME_W-1:0] now);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= cmd;
    req_ch.core_index <= core;
    req_ch.now        <= now;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(apply_command(cmd, core, now));
  endtask

  // Hold the sender off until every expected word has come back.
  task automatic wait_until_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the period register while the unit is idle.
  task automatic write_period(logic [TICK_W-1:0] value);
    wait_until_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    tick_period = value;
    cfg_we <= 1'b0;
    period_writes++;
  endtask

  // Receiver: random back-pressure on the response channel.
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare every accepted response word with the oldest prediction.
  always @(posedge clk) begin
    tick_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("response word with nothing expected", rsp_ch.next_deadline, '0);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (rsp_ch.ticks !== want.ticks)
          report_mismatch("ticks", TIME_W'(rsp_ch.ticks), TIME_W'(want.ticks));
        if (rsp_ch.next_deadline !== want.next_deadline)
          report_mismatch("next_deadline", rsp_ch.next_deadline, want.next_deadline);
        if (rsp_ch.elapsed_cycles !== want.elapsed_cycles)
          report_mismatch("elapsed_cycles", rsp_ch.elapsed_cycles, want.elapsed_cycles);
      end
    end
  end

  // Reads straight after reset and first events with the reset period.
  task automatic test_reset_state();
    send_word(CMD_READ, 2'd0, 64'd1500);
    send_word(CMD_READ, 2'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(CMD_READ, 2'd2, 64'd0);
    send_word(CMD_READ, 2'd3, 64'h8000_0000_0000_0001);
    send_word(CMD_EVENT, 2'd0, 64'd0);
    // Restart near the top of the time range wraps the new deadline.
    send_word(CMD_EVENT, 2'd1, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // Restart, exact hits, several missed periods, and a read before the next deadline.
  task automatic test_catch_up();
    send_word(CMD_EVENT, 2'd2, 64'd5000);
    send_word(CMD_EVENT, 2'd2, 64'd6000);
    send_word(CMD_EVENT, 2'd2, 64'd10999);
    send_word(CMD_EVENT, 2'd2, 64'd11000);
    send_word(CMD_READ,  2'd2, 64'd11500);
  endtask

  // A period register of zero behaves as a one-cycle period.
  task automatic test_zero_period();
    write_period(32'd0);
    send_word(CMD_EVENT, 2'd3, 64'd100);
    send_word(CMD_EVENT, 2'd3, 64'd105);
    send_word(CMD_READ,  2'd3, 64'd200);
  endtask

  // Tick count just below, at and far beyond the saturation point.
  task automatic test_tick_saturation();
    write_period(32'd1);
    send_word(CMD_EVENT, 2'd1, core_deadline[1] + 64'hFFFF_FFFE);
    send_word(CMD_EVENT, 2'd1, core_deadline[1] + 64'hFFFF_FFFF);
    send_word(CMD_EVENT, 2'd1, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // Largest period, with deadlines wrapping around the time range.
  task automatic test_wide_period();
    write_period(32'hFFFF_FFFF);
    send_word(CMD_EVENT, 2'd3, 64'hFFFF_FFFF_0000_0000);
    send_word(CMD_EVENT, 2'd3, core_deadline[3] + 2 * tick_length());
    send_word(CMD_READ,  2'd3, core_deadline[3]);
  endtask

  // One random word, mostly aimed at the current deadline of its core.
  task automatic send_random_word();
    logic [CORE_W-1:0] core;
    logic [TIME_W-1:0] due;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] now;
    logic              cmd;
    int unsigned       pick;
    core   = CORE_W'($urandom_range(0, (1 << CORE_W) - 1));
    due    = (int'(core) < CORES) ? core_deadline[core] : '0;
    period = tick_length();
    pick   = $urandom_range(0, 99);
    cmd    = CMD_EVENT;
    if (pick < 8) begin
      cmd = CMD_READ;
      now = due + 64'($urandom_range(0, 65535));
    end else if (pick < 15) begin
      cmd = CMD_READ;
      now = {$urandom, $urandom};
    end else if (pick < 70) begin
      // Regular interrupt: a few whole periods late plus a partial one.
      if (due == '0) begin
        now = {$urandom, $urandom};
      end else begin
        now = due + 64'($urandom_range(0, 6)) * period
            + 64'($urandom_range(0, 32'(period - 64'd1)));
      end
    end else if (pick < 80) begin
      now = due - 64'd1 - 64'($urandom_range(0, 999));
    end else if (pick < 88) begin
      now = due;
    end else if (pick < 94) begin
      now = due + period * (64'hFFFF_FFFE + 64'($urandom_range(0, 2)));
    end else begin
      now = {$urandom, $urandom};
    end
    send_word(cmd, core, now);
  endtask

  // Random traffic in three chunks, each with its own period setting.
  task automatic test_random_traffic(int words, int gap_pct, int stall_pct);
    logic [TICK_W-1:0] next_period;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    for (int chunk = 0; chunk < 3; chunk++) begin
      case (chunk)
        0: next_period = $urandom_range(1, 64);
        1: next_period = $urandom_range(1000, 1000000);
        default: next_period = $urandom;
      endcase
      write_period(next_period);
      for (int n = 0; n < words / 3; n++) begin
        // Let the unit run dry once mid-chunk before sending again.
        if (chunk == 1 && n == words / 6) begin
          wait_until_drained();
        end
        send_random_word();
      end
    end
  endtask

  // Main sequence.
  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.cmd        <= CMD_EVENT;
    req_ch.core_index <= '0;
    req_ch.now        <= '0;
    tick_period = CPT_RESET;
    for (int k = 0; k < CORES; k++) begin
      core_deadline[k]      = '0;
      core_prev_deadline[k] = '0;
    end
    send_gap_pct   = 13;
    recv_stall_pct = 52;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_catch_up();
    test_zero_period();
    test_tick_saturation();
    test_wide_period();
    test_random_traffic(234, 13, 52);
    test_random_traffic(234, 52, 13);
    test_random_traffic(234, 0, 0);
    wait_until_drained();

    $display("Covered %0d interrupt events and %0d reads, %0d response words checked.",
             event_count, read_count, checked_count);
    $display("Period written %0d times, zero and all ones included; %0d tick counts saturated.",
             period_writes, saturated_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
